@@ rtl/core/kma_pkg.sv @@
package kma_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int ACCUM_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_KEY    = 3'd2,
    KIND_MOTION = 3'd3,
    KIND_BUTTON = 3'd4,
    KIND_SYNC   = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SYNC_HDR = 5'b00010,
    S_SYNC_X   = 5'b00100,
    S_SYNC_Y   = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  localparam logic [1:0] OFFS_STATUS   = 2'd0;
  localparam logic [1:0] OFFS_DATA     = 2'd2;
  localparam logic [2:0] MAX_ACCESS    = 3'd2;

  localparam logic [7:0] CMD_ARM       = 8'h80;
  localparam logic [7:0] CMD_RESET     = 8'h01;
  localparam logic [7:0] RESET_REPLY   = 8'hF0;
  localparam logic [7:0] PKT_HEADER    = 8'hF8;

  localparam logic [3:0] BTN_LEFT      = 4'd0;
  localparam logic [3:0] BTN_RIGHT     = 4'd1;
  localparam logic [3:0] BTN_LAST      = 4'd8;
  localparam logic [1:0] BUTTONS_RESET = 2'b11;

  function automatic logic [6:0] btn_code(input logic [3:0] btn);
    logic [6:0] code;
    case (btn)
      4'd2:    code = 7'h37;
      4'd3:    code = 7'h5E;
      4'd4:    code = 7'h5F;
      4'd5:    code = 7'h59;
      4'd6:    code = 7'h5A;
      4'd7:    code = 7'h5C;
      4'd8:    code = 7'h5D;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/core/kma_if.sv @@
interface kma_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [1:0]        reg_offset;
  logic [2:0]        access_size;
  logic [7:0]        write_data;
  logic [6:0]        scan_code;
  logic              pressed;
  logic              axis;
  logic signed [15:0] motion;
  logic [3:0]        button;

  modport source (
    output valid, kind, reg_offset, access_size, write_data, scan_code,
           pressed, axis, motion, button,
    input  ready
  );
  modport sink (
    input  valid, kind, reg_offset, access_size, write_data, scan_code,
           pressed, axis, motion, button,
    output ready
  );
endinterface

interface kma_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;

  modport source (output valid, read_data, irq, input ready);
  modport sink (input valid, read_data, irq, output ready);
endinterface

@@ rtl/core/keyboard_mouse_acia_controller.sv @@
// Keyboard and mouse serial controller seen through a status/control byte
// register and a data/command byte register.
// Every request on in_ch (bus read, bus write, key event, mouse motion,
// mouse button or sync) yields exactly one response on out_ch carrying the
// byte returned by a bus read (0 otherwise) and the interrupt level after
// the request.
// Received bytes live in a single-ported queue memory of QUEUE_DEPTH bytes
// with a registered read; a data read fetches the head entry into the read
// register, and the done state passes it on to the output register.
// A request is handled in two steps: the idle state acts on the state, and
// the done state places the response in the output register. A sync request
// passes through the header, X and Y states for each mouse packet, one queue
// write per byte; the packet count is limited by the free room in the queue.
// The output register decouples the two sides: a new request is taken
// while an earlier response still waits; if out_ch stalls, the block holds
// the next finished response and stops taking requests until it moves.
// Synchronous reset empties the queue, clears the control byte, the
// accumulators and the command state, and sets both button bits; no
// clearing pass is needed.
module keyboard_mouse_acia_controller
  import kma_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  kma_in_if.sink    in_ch,
  kma_out_if.source out_ch
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = ((ACCUM_WIDTH > 16) ? ACCUM_WIDTH : 16) + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(QUEUE_DEPTH - 3);
  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
  localparam logic signed [ACCUM_WIDTH-1:0] CLAMP_HI = ACCUM_WIDTH'(127);
  localparam logic signed [ACCUM_WIDTH-1:0] CLAMP_LO = ACCUM_WIDTH'(-128);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [ACCUM_WIDTH-1:0] a);
    logic [7:0] b;
    if (a > CLAMP_HI) begin
      b = 8'h7F;
    end else if (a < CLAMP_LO) begin
      b = 8'h80;
    end else begin
      b = a[7:0];
    end
    return b;
  endfunction

  logic [7:0] q_mem [QUEUE_DEPTH];

  state_t                         state_r, state_nxt;
  logic [PTR_W-1:0]               head_r, head_nxt;
  logic [PTR_W-1:0]               tail_r, tail_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [7:0]                     control_r, control_nxt;
  logic [1:0]                     buttons_r, buttons_nxt;
  logic signed [ACCUM_WIDTH-1:0]  acc_x_r, acc_x_nxt;
  logic signed [ACCUM_WIDTH-1:0]  acc_y_r, acc_y_nxt;
  logic                           armed_r, armed_nxt;
  logic [7:0]                     res_data_r, res_data_nxt;
  logic                           pop_r, pop_nxt;
  logic [7:0]                     mem_rd_r;
  logic                           out_valid_r;
  logic [7:0]                     read_data_r;
  logic                           irq_r;

  logic                           mem_we;
  logic [PTR_W-1:0]               mem_wa;
  logic [7:0]                     mem_wd;
  logic                           mem_re;
  logic                           in_fire;
  logic                           out_load;
  logic                           bus_ok;
  logic                           not_empty;
  logic signed [SUM_W-1:0]        motion_sum;
  logic signed [ACCUM_WIDTH-1:0]  motion_sat;
  logic [7:0]                     cx, cy;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign bus_ok      = (in_ch.access_size <= MAX_ACCESS);
  assign not_empty   = (count_r != '0);
  assign cx          = clamp8(acc_x_r);
  assign cy          = clamp8(acc_y_r);

  always_comb begin
    motion_sum = (in_ch.axis ? SUM_W'(acc_y_r) : SUM_W'(acc_x_r)) + SUM_W'(in_ch.motion);
    if (motion_sum > SUM_W'(ACC_MAX)) begin
      motion_sat = ACC_MAX;
    end else if (motion_sum < SUM_W'(ACC_MIN)) begin
      motion_sat = ACC_MIN;
    end else begin
      motion_sat = motion_sum[ACCUM_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    control_nxt  = control_r;
    buttons_nxt  = buttons_r;
    acc_x_nxt    = acc_x_r;
    acc_y_nxt    = acc_y_r;
    armed_nxt    = armed_r;
    res_data_nxt = res_data_r;
    pop_nxt      = pop_r;
    mem_we       = 1'b0;
    mem_wa       = tail_r;
    mem_wd       = '0;
    mem_re       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt    = S_DONE;
          res_data_nxt = '0;
          pop_nxt      = 1'b0;
          case (in_ch.kind)
            KIND_READ: begin
              if (bus_ok && in_ch.reg_offset == OFFS_STATUS) begin
                res_data_nxt = {control_r[7] && not_empty, 5'b00000, 1'b1, not_empty};
              end else if (bus_ok && in_ch.reg_offset == OFFS_DATA && not_empty) begin
                mem_re    = 1'b1;
                pop_nxt   = 1'b1;
                head_nxt  = ptr_inc(head_r);
                count_nxt = count_r - 1'b1;
              end
            end
            KIND_WRITE: begin
              if (bus_ok && in_ch.reg_offset == OFFS_STATUS) begin
                control_nxt = in_ch.write_data;
              end else if (bus_ok && in_ch.reg_offset == OFFS_DATA) begin
                if (in_ch.write_data == CMD_ARM) begin
                  armed_nxt = 1'b1;
                end else if (in_ch.write_data == CMD_RESET && armed_r) begin
                  armed_nxt   = 1'b0;
                  buttons_nxt = BUTTONS_RESET;
                  acc_x_nxt   = '0;
                  acc_y_nxt   = '0;
                  mem_we      = 1'b1;
                  mem_wa      = '0;
                  mem_wd      = RESET_REPLY;
                  head_nxt    = '0;
                  tail_nxt    = ptr_inc('0);
                  count_nxt   = CNT_W'(1);
                end
              end
            end
            KIND_KEY: begin
              if (in_ch.scan_code != '0 && count_r != CNT_FULL) begin
                mem_we    = 1'b1;
                mem_wd    = {!in_ch.pressed, in_ch.scan_code};
                tail_nxt  = ptr_inc(tail_r);
                count_nxt = count_r + 1'b1;
              end
            end
            KIND_MOTION: begin
              if (in_ch.axis) begin
                acc_y_nxt = motion_sat;
              end else begin
                acc_x_nxt = motion_sat;
              end
            end
            KIND_BUTTON: begin
              if (in_ch.button == BTN_LEFT) begin
                buttons_nxt[1] = in_ch.pressed;
              end else if (in_ch.button == BTN_RIGHT) begin
                buttons_nxt[0] = in_ch.pressed;
              end else if (in_ch.button <= BTN_LAST && count_r != CNT_FULL) begin
                mem_we    = 1'b1;
                mem_wd    = {!in_ch.pressed, btn_code(in_ch.button)};
                tail_nxt  = ptr_inc(tail_r);
                count_nxt = count_r + 1'b1;
              end
            end
            KIND_SYNC: begin
              if (count_r <= CNT_ROOM) begin
                state_nxt = S_SYNC_HDR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SYNC_HDR: begin
        mem_we    = 1'b1;
        mem_wd    = PKT_HEADER | {6'b000000, buttons_r};
        tail_nxt  = ptr_inc(tail_r);
        count_nxt = count_r + 1'b1;
        state_nxt = S_SYNC_X;
      end
      S_SYNC_X: begin
        mem_we    = 1'b1;
        mem_wd    = cx;
        tail_nxt  = ptr_inc(tail_r);
        count_nxt = count_r + 1'b1;
        state_nxt = S_SYNC_Y;
      end
      S_SYNC_Y: begin
        mem_we    = 1'b1;
        mem_wd    = cy;
        tail_nxt  = ptr_inc(tail_r);
        count_nxt = count_r + 1'b1;
        acc_x_nxt = acc_x_r - ACCUM_WIDTH'($signed(cx));
        acc_y_nxt = acc_y_r - ACCUM_WIDTH'($signed(cy));
        if ((acc_x_nxt == '0 && acc_y_nxt == '0) || count_nxt > CNT_ROOM) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SYNC_HDR;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      q_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= q_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      control_r   <= '0;
      buttons_r   <= BUTTONS_RESET;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      armed_r     <= 1'b0;
      pop_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      control_r <= control_nxt;
      buttons_r <= buttons_nxt;
      acc_x_r   <= acc_x_nxt;
      acc_y_r   <= acc_y_nxt;
      armed_r   <= armed_nxt;
      pop_r     <= pop_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_data_r <= res_data_nxt;
    if (out_load) begin
      read_data_r <= pop_r ? mem_rd_r : res_data_r;
      irq_r       <= control_r[7] && not_empty;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = read_data_r;
  assign out_ch.irq       = irq_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("Queue count exceeds the queue depth.");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_FULL) |-> head_r == tail_r)
    else $error("Queue pointers disagree with the count.");

  a_sync_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SYNC_HDR |-> count_r <= CNT_ROOM)
    else $error("Packet started without room for three bytes.");

  a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("Response appeared without a finished request.");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import kma_pkg::*;

  localparam logic [2:0] KIND_SPARE  = 3'd6;
  localparam logic [1:0] OFFS_ODD    = 2'd1;
  localparam logic [7:0] STAT_RX     = 8'h01;
  localparam logic [7:0] STAT_TX     = 8'h02;
  localparam logic [7:0] STAT_IRQ    = 8'h80;
  localparam logic [7:0] CTRL_IRQ_EN = 8'h80;
  localparam logic [7:0] REL_BIT     = 8'h80;
  localparam logic [7:0] CMD_OTHER   = 8'h55;
  localparam int         ACC_HI      = (1 << (ACCUM_WIDTH_DEF - 1)) - 1;
  localparam int         ACC_LO      = -(1 << (ACCUM_WIDTH_DEF - 1));
  localparam int         RANDOM_REQS = 572;
  localparam int         CALM_REQS   = 100;
  localparam logic [6:0] BTN_SCAN [0:8] = '{7'h00, 7'h00, 7'h37, 7'h5E, 7'h5F,
                                            7'h59, 7'h5A, 7'h5C, 7'h5D};

  typedef struct {
    logic [2:0]         kind;
    logic [1:0]         offs;
    logic [2:0]         size;
    logic [7:0]         wdata;
    logic [6:0]         scan;
    logic               pressed;
    logic               axis;
    logic signed [15:0] motion;
    logic [3:0]         button;
  } req_t;

  typedef struct {
    logic [7:0] rd;
    logic       irq;
  } resp_t;

  typedef struct {
    req_t  r;
    bit    typed;
    resp_t want;
  } row_t;

  logic clk;
  logic rst_n;

  kma_in_if  in_ch ();
  kma_out_if out_ch ();

  keyboard_mouse_acia_controller uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [7:0] rx_fifo [$];
  logic [7:0] ctl_byte;
  logic [1:0] btn_bits;
  int         acc_x;
  int         acc_y;
  bit         armed;
  bit         arm_open;
  bit         calm;
  int         quiet_in;
  int         errors;
  resp_t      resp_due [$];
  row_t       script [28];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void enqueue(input logic [7:0] b);
    if (rx_fifo.size() < QUEUE_DEPTH_DEF) rx_fifo.push_back(b);
  endfunction

  function automatic int saturate(input int v);
    return (v > ACC_HI) ? ACC_HI : (v < ACC_LO) ? ACC_LO : v;
  endfunction

  function automatic int clamp_byte(input int v);
    return (v > 127) ? 127 : (v < -128) ? -128 : v;
  endfunction

  function automatic resp_t predict_response(input req_t r);
    resp_t o;
    int    cx;
    int    cy;
    o.rd = 8'h00;
    case (r.kind)
      KIND_READ: begin
        if (r.size <= MAX_ACCESS) begin
          if (r.offs == OFFS_STATUS) begin
            o.rd = STAT_TX;
            if (rx_fifo.size() != 0) o.rd |= ctl_byte[7] ? (STAT_RX | STAT_IRQ) : STAT_RX;
          end else if (r.offs == OFFS_DATA && rx_fifo.size() != 0) begin
            o.rd = rx_fifo.pop_front();
          end
        end
      end
      KIND_WRITE: begin
        if (r.size <= MAX_ACCESS) begin
          if (r.offs == OFFS_STATUS) begin
            ctl_byte = r.wdata;
          end else if (r.offs == OFFS_DATA) begin
            if (r.wdata == CMD_ARM) begin
              armed = 1'b1;
            end else if (r.wdata == CMD_RESET && armed) begin
              rx_fifo.delete();
              btn_bits = BUTTONS_RESET;
              acc_x = 0;
              acc_y = 0;
              armed = 1'b0;
              enqueue(RESET_REPLY);
            end
          end
        end
      end
      KIND_KEY: begin
        if (r.scan != 7'h00) enqueue({~r.pressed, r.scan});
      end
      KIND_MOTION: begin
        if (r.axis == 1'b0) acc_x = saturate(acc_x + r.motion);
        else acc_y = saturate(acc_y + r.motion);
      end
      KIND_BUTTON: begin
        if (r.button == BTN_LEFT) btn_bits[1] = r.pressed;
        else if (r.button == BTN_RIGHT) btn_bits[0] = r.pressed;
        else if (r.button <= BTN_LAST) enqueue({~r.pressed, BTN_SCAN[r.button]});
      end
      KIND_SYNC: begin
        while (QUEUE_DEPTH_DEF - rx_fifo.size() >= 3) begin
          cx = clamp_byte(acc_x);
          cy = clamp_byte(acc_y);
          enqueue(PKT_HEADER | {6'd0, btn_bits});
          enqueue(cx[7:0]);
          enqueue(cy[7:0]);
          acc_x -= cx;
          acc_y -= cy;
          if (acc_x == 0 && acc_y == 0) break;
        end
      end
      default: begin
      end
    endcase
    o.irq = (rx_fifo.size() != 0) && ctl_byte[7];
    return o;
  endfunction

  function automatic req_t draw_request();
    req_t r;
    int   pick;
    r.kind    = 3'($urandom_range(0, 7));
    r.offs    = 2'($urandom);
    r.size    = 3'($urandom);
    r.wdata   = 8'($urandom);
    r.scan    = 7'($urandom);
    r.pressed = 1'($urandom);
    r.axis    = 1'($urandom);
    r.motion  = 16'($urandom);
    r.button  = 4'($urandom);
    pick = $urandom_range(0, 99);
    if (arm_open && pick < 60) begin
      r.kind  = KIND_WRITE;
      r.offs  = OFFS_DATA;
      r.size  = 3'($urandom_range(0, 2));
      r.wdata = CMD_RESET;
    end else if (pick < 40) begin
      r.kind = KIND_READ;
      if ($urandom_range(0, 9) != 0) begin
        r.offs = $urandom_range(0, 2) != 0 ? OFFS_DATA : OFFS_STATUS;
        r.size = 3'($urandom_range(0, 2));
      end
    end else if (pick < 48) begin
      r.kind = KIND_WRITE;
      if ($urandom_range(0, 9) != 0) r.size = 3'($urandom_range(0, 2));
      if ($urandom_range(0, 1) != 0) begin
        r.offs = OFFS_STATUS;
      end else begin
        r.offs = OFFS_DATA;
        case ($urandom_range(0, 2))
          0: r.wdata = CMD_ARM;
          1: r.wdata = CMD_RESET;
          default: begin
          end
        endcase
      end
    end else if (pick < 62) begin
      r.kind = KIND_KEY;
    end else if (pick < 74) begin
      r.kind = KIND_MOTION;
      if ($urandom_range(0, 3) != 0) r.motion = 16'($urandom_range(0, 600)) - 16'd300;
    end else if (pick < 86) begin
      r.kind = KIND_BUTTON;
    end else if (pick < 96) begin
      r.kind = KIND_SYNC;
    end else begin
      r.kind = 3'($urandom_range(KIND_SPARE, 7));
    end
    arm_open = (r.kind == KIND_WRITE && r.offs == OFFS_DATA && r.wdata == CMD_ARM);
    return r;
  endfunction

  task automatic send_request(input req_t r, input bit typed, input resp_t want);
    resp_t got;
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= r.kind;
    in_ch.reg_offset  <= r.offs;
    in_ch.access_size <= r.size;
    in_ch.write_data  <= r.wdata;
    in_ch.scan_code   <= r.scan;
    in_ch.pressed     <= r.pressed;
    in_ch.axis        <= r.axis;
    in_ch.motion      <= r.motion;
    in_ch.button      <= r.button;
    do @(posedge clk); while (!in_ch.ready);
    got = predict_response(r);
    resp_due.push_back(typed ? want : got);
    if (quiet_in > 0) begin
      quiet_in--;
    end else if (!calm) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3: begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        4: quiet_in = $urandom_range(10, 40);
        default: begin
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    resp_t exp_resp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (resp_due.size() == 0) begin
        log_mismatch($sformatf("response with none outstanding: read_data %02h irq %0b",
                               out_ch.read_data, out_ch.irq));
      end else begin
        exp_resp = resp_due.pop_front();
        if (out_ch.read_data !== exp_resp.rd)
          log_mismatch($sformatf("read_data %02h, expected %02h",
                                 out_ch.read_data, exp_resp.rd));
        if (out_ch.irq !== exp_resp.irq)
          log_mismatch($sformatf("irq %0b, expected %0b", out_ch.irq, exp_resp.irq));
      end
    end
  end

  initial begin
    int hold;
    int quiet;
    hold  = 0;
    quiet = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (calm || quiet > 0) begin
        if (quiet > 0) quiet--;
        out_ch.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 15))
          0, 1, 2: begin
            hold = $urandom_range(0, 4);
            out_ch.ready <= 1'b0;
          end
          3: begin
            quiet = $urandom_range(20, 80);
            out_ch.ready <= 1'b1;
          end
          default: out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    resp_t none;
    none      = '{8'h00, 1'b0};
    rx_fifo.delete();
    ctl_byte  = 8'h00;
    btn_bits  = BUTTONS_RESET;
    acc_x     = 0;
    acc_y     = 0;
    armed     = 1'b0;
    arm_open  = 1'b0;
    calm      = 1'b0;
    quiet_in  = 0;
    errors    = 0;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_READ;
    in_ch.reg_offset  = OFFS_STATUS;
    in_ch.access_size = 3'd1;
    in_ch.write_data  = 8'h00;
    in_ch.scan_code   = 7'h00;
    in_ch.pressed     = 1'b0;
    in_ch.axis        = 1'b0;
    in_ch.motion      = 16'h0000;
    in_ch.button      = 4'd0;

    script = '{
      '{'{KIND_READ,   OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{STAT_TX, 1'b0}},
      '{'{KIND_READ,   OFFS_DATA,   3'd2, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{8'h00, 1'b0}},
      '{'{KIND_WRITE,  OFFS_STATUS, 3'd1, CTRL_IRQ_EN, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{8'h00, 1'b0}},
      '{'{KIND_KEY,    OFFS_STATUS, 3'd1, 8'h00, 7'h7F, 1'b1, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{8'h00, 1'b1}},
      '{'{KIND_KEY,    OFFS_STATUS, 3'd1, 8'h00, 7'h01, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{8'h00, 1'b1}},
      '{'{KIND_KEY,    OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b1, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{8'h00, 1'b1}},
      '{'{KIND_READ,   OFFS_STATUS, 3'd2, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{STAT_IRQ | STAT_TX | STAT_RX, 1'b1}},
      '{'{KIND_READ,   OFFS_DATA,   3'd4, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{8'h00, 1'b1}},
      '{'{KIND_READ,   OFFS_ODD,    3'd1, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{8'h00, 1'b1}},
      '{'{KIND_READ,   OFFS_DATA,   3'd1, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{8'h7F, 1'b1}},
      '{'{KIND_READ,   OFFS_DATA,   3'd0, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{REL_BIT | 8'h01, 1'b0}},
      '{'{KIND_MOTION, OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b0, 1'b0, 16'h7FFF, 4'd0}, 1'b0,
        none},
      '{'{KIND_MOTION, OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b0, 1'b0, 16'd1000, 4'd0}, 1'b0,
        none},
      '{'{KIND_MOTION, OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b0, 1'b1, 16'h8000, 4'd0}, 1'b0,
        none},
      '{'{KIND_BUTTON, OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, BTN_LEFT}, 1'b0,
        none},
      '{'{KIND_BUTTON, OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b1, 1'b0, 16'h0, 4'd2}, 1'b0,
        none},
      '{'{KIND_BUTTON, OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, BTN_LAST}, 1'b0,
        none},
      '{'{KIND_BUTTON, OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b1, 1'b0, 16'h0, 4'd15}, 1'b0,
        none},
      '{'{KIND_SYNC,   OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b0,
        none},
      '{'{KIND_KEY,    OFFS_STATUS, 3'd1, 8'h00, 7'h1C, 1'b1, 1'b0, 16'h0, 4'd0}, 1'b0,
        none},
      '{'{KIND_KEY,    OFFS_STATUS, 3'd1, 8'h00, 7'h2A, 1'b1, 1'b0, 16'h0, 4'd0}, 1'b0,
        none},
      '{'{KIND_KEY,    OFFS_STATUS, 3'd1, 8'h00, 7'h39, 1'b1, 1'b0, 16'h0, 4'd0}, 1'b0,
        none},
      '{'{KIND_SYNC,   OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b0,
        none},
      '{'{KIND_WRITE,  OFFS_DATA,   3'd1, CMD_RESET, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b0,
        none},
      '{'{KIND_WRITE,  OFFS_DATA,   3'd1, CMD_ARM, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b0,
        none},
      '{'{KIND_WRITE,  OFFS_DATA,   3'd2, CMD_OTHER, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b0,
        none},
      '{'{KIND_WRITE,  OFFS_DATA,   3'd1, CMD_RESET, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b0,
        none},
      '{'{KIND_READ,   OFFS_DATA,   3'd1, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0}, 1'b1,
        '{RESET_REPLY, 1'b0}}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send_request(script[i].r, script[i].typed, script[i].want);
    send_request('{KIND_SPARE, OFFS_STATUS, 3'd1, 8'h00, 7'h00, 1'b0, 1'b0, 16'h0, 4'd0},
                 1'b0, none);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      calm = (n >= RANDOM_REQS - CALM_REQS);
      if (n % 150 == 75 && resp_due.size() != 0) begin
        in_ch.valid <= 1'b0;
        while (resp_due.size() != 0) @(posedge clk);
      end
      send_request(draw_request(), 1'b0, none);
    end
    in_ch.valid <= 1'b0;

    while (resp_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
